>>> sv/tep_pkg.sv
// ----------------------------------------------------------------------------
// Timed event priority queue package
// Shared types, sizes and codes for the event queue controller and datapath.
// ----------------------------------------------------------------------------
package tep_pkg;

  localparam int QueueDepth = 16;
  localparam int KindBits   = 4;
  localparam int KindW      = 4;
  localparam int CountW     = 5;
  localparam int TimeW      = 64;
  localparam int AmountW    = 32;

  localparam logic [TimeW-1:0] AllOnes = {TimeW{1'b1}};

  typedef enum logic [2:0] {
    OP_SCHEDULE   = 3'd0,
    OP_DESCHEDULE = 3'd1,
    OP_ADVANCE    = 3'd2,
    OP_PROCESS    = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [KindW-1:0]   event_kind;
    logic [AmountW-1:0] amount;
  } in_beat_t;

  typedef struct packed {
    logic               fired;
    logic [KindW-1:0]   fired_kind;
    logic [TimeW-1:0]   next_delay;
    logic [CountW-1:0]  pending_count;
    logic               dropped;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic latch;
    logic calc_time;
    logic insert;
    logic desch_step;
    logic advance;
    logic clear;
    logic pop;
    logic load_out;
    logic fired;
    logic dropped;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       full;
    logic       head_due;
    logic       desch_hit;
    logic       out_free;
  } dp_status_t;

endpackage

>>> sv/timed_event_priority_queue.sv
// ----------------------------------------------------------------------------
// Timed event priority queue
// Cycle counter with a bounded store of events kept sorted by fire time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat
//   in       input      in_valid_i/in_stall_o  opcode, event_kind, amount
//   out      output     out_valid_o/out_stall_i fired .. last, one per result
//
// Schedule steps through latch, fire-time calculation, insertion and result
// load, skipping insertion when the store is full; advance, clear and unknown
// opcodes go from latch straight to the result load. Deschedule removes the
// matching events one at a time, since the store closes up one gap a cycle.
// Process pops each due event and loads its result, or loads one result if none is due.
// Reset empties the store and zeroes the counter; no clearing pass is needed.
// A stalled output holds its registered beat and the controller waits with it.
// ----------------------------------------------------------------------------
module timed_event_priority_queue
  import tep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  // The controller decides the order of operations; the datapath owns all
  // the storage, including the result register that decouples the output.
  dp_cmd_t    cmd;
  dp_status_t status;

  tep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tep_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/tep_ctrl.sv
// ----------------------------------------------------------------------------
// Event queue controller
// Sequences one input beat at a time through the datapath operations.
// ----------------------------------------------------------------------------
module tep_ctrl
  import tep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_INS   = 6'b000100,
    ST_DESCH = 6'b001000,
    ST_PROC  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic              resp_q, resp_d;
  logic              drop_q, drop_d;
  logic [CountW-1:0] n_q, n_d;
  logic [CountW:0]   n_next;

  assign in_stall_o = (state_q != ST_IDLE);
  assign n_next     = {1'b0, n_q} + {{CountW{1'b0}}, 1'b1};

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    drop_d  = drop_q;
    n_d     = n_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          n_d         = '0;
          drop_d      = 1'b0;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.opcode)
          OP_SCHEDULE: begin
            if (status_i.full) begin
              drop_d  = 1'b1;
              resp_d  = 1'b1;
              state_d = ST_EMIT;
            end else begin
              cmd_o.calc_time = 1'b1;
              state_d         = ST_INS;
            end
          end
          OP_DESCHEDULE: state_d = ST_DESCH;
          OP_ADVANCE: begin
            cmd_o.advance = 1'b1;
            resp_d        = 1'b1;
            state_d       = ST_EMIT;
          end
          OP_PROCESS: state_d = ST_PROC;
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            resp_d      = 1'b1;
            state_d     = ST_EMIT;
          end
          default: begin
            resp_d  = 1'b1;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_INS: begin
        cmd_o.insert = 1'b1;
        resp_d       = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_DESCH: begin
        if (status_i.desch_hit) begin
          cmd_o.desch_step = 1'b1;
        end else begin
          resp_d  = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_PROC: begin
        if (status_i.head_due) begin
          cmd_o.pop = 1'b1;
          resp_d    = 1'b0;
        end else begin
          resp_d    = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.dropped  = drop_q;
          if (resp_q) begin
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            // Another event follows only if the new head is due as well and
            // the per-beat result limit has not been reached.
            cmd_o.fired = 1'b1;
            n_d         = n_next[CountW-1:0];
            if (status_i.head_due && (n_next < (CountW+1)'(QueueDepth))) begin
              state_d = ST_PROC;
            end else begin
              cmd_o.last = 1'b1;
              state_d    = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      resp_q  <= 1'b0;
      drop_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
      drop_q  <= drop_d;
      n_q     <= n_d;
    end
  end

endmodule

>>> sv/tep_dpath.sv
// ----------------------------------------------------------------------------
// Event queue datapath
// Sorted event store, cycle counter and the registered result stage.
// ----------------------------------------------------------------------------
module tep_dpath
  import tep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_beat_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_data_o
);

  logic [TimeW-1:0]  time_q [QueueDepth];
  logic [TimeW-1:0]  time_d [QueueDepth];
  logic [KindW-1:0]  kind_q [QueueDepth];
  logic [KindW-1:0]  kind_d [QueueDepth];
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [TimeW-1:0]  t_q;
  in_beat_t          op_q;
  logic [KindW-1:0]  popped_q;
  logic              out_valid_q;
  out_beat_t         out_q;

  logic [TimeW:0]    sum;
  logic [TimeW-1:0]  sat_sum;
  logic [QueueDepth-1:0] le, hit, hit_upto;
  logic [KindW-1:0]  key;
  logic              head_due;
  logic [TimeW-1:0]  head_delay;

  // One saturating adder serves both the fire time and the counter advance.
  assign sum     = {1'b0, now_q} + {{(TimeW+1-AmountW){1'b0}}, op_q.amount};
  assign sat_sum = sum[TimeW] ? AllOnes : sum[TimeW-1:0];
  assign key     = KindW'(op_q.event_kind[KindBits-1:0]);

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      le[i]  = (CountW'(i) < count_q) && (time_q[i] <= t_q);
      hit[i] = (CountW'(i) < count_q) && (kind_q[i] == key);
    end
    hit_upto[0] = hit[0];
    for (int i = 1; i < QueueDepth; i++) begin
      hit_upto[i] = hit_upto[i-1] | hit[i];
    end
  end

  assign head_due   = (count_q != '0) && (time_q[0] <= now_q);
  assign head_delay = (count_q == '0) ? AllOnes :
                      (head_due ? '0 : (time_q[0] - now_q));

  always_comb begin
    time_d  = time_q;
    kind_d  = kind_q;
    count_d = count_q;
    now_d   = now_q;
    if (cmd_i.insert) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
            time_d[i] = t_q;
            kind_d[i] = key;
          end else begin
            time_d[i] = time_q[(i == 0) ? 0 : i-1];
            kind_d[i] = kind_q[(i == 0) ? 0 : i-1];
          end
        end
      end
      count_d = count_q + CountW'(1);
    end else if (cmd_i.desch_step) begin
      for (int i = 0; i < QueueDepth-1; i++) begin
        if (hit_upto[i]) begin
          time_d[i] = time_q[i+1];
          kind_d[i] = kind_q[i+1];
        end
      end
      count_d = count_q - CountW'(1);
    end else if (cmd_i.pop) begin
      for (int i = 0; i < QueueDepth-1; i++) begin
        time_d[i] = time_q[i+1];
        kind_d[i] = kind_q[i+1];
      end
      count_d = count_q - CountW'(1);
    end else if (cmd_i.clear) begin
      count_d = '0;
      now_d   = '0;
    end else if (cmd_i.advance) begin
      now_d = sat_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    kind_q <= kind_d;
    if (cmd_i.latch) begin
      op_q <= in_data_i;
    end
    if (cmd_i.calc_time) begin
      t_q <= sat_sum;
    end
    if (cmd_i.pop) begin
      popped_q <= kind_q[0];
    end
    if (cmd_i.load_out) begin
      out_q.fired         <= cmd_i.fired;
      out_q.fired_kind    <= cmd_i.fired ? popped_q : '0;
      out_q.next_delay    <= head_delay;
      out_q.pending_count <= count_q;
      out_q.dropped       <= cmd_i.dropped;
      out_q.last          <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      now_q   <= now_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.opcode    = op_q.opcode;
  assign status_o.full      = (count_q == CountW'(QueueDepth));
  assign status_o.head_due  = head_due;
  assign status_o.desch_hit = |hit;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Timed event priority queue testbench
// Drives opcode beats through a valid/stall channel, predicts every result
// beat with a behavioural copy of the sorted event store and compares them.
// ----------------------------------------------------------------------------
module testbench;
  import tep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  timed_event_priority_queue dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Shadow of the block's state: the counter and the sorted event store.
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] fire_time_q[$];
  logic [KindW-1:0] fire_kind_q[$];

  in_beat_t  pending_beats[$];
  out_beat_t expected_beats[$];

  int        errors;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_off_cycles;
  bit        driver_hold;
  bit        in_taken;

  function automatic logic [TimeW-1:0] sat_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? AllOnes : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] head_gap();
    if (fire_time_q.size() == 0) return AllOnes;
    if (fire_time_q[0] <= now_q) return '0;
    return fire_time_q[0] - now_q;
  endfunction

  function automatic out_beat_t plain_result(logic fired, logic [KindW-1:0] kind, logic drop);
    out_beat_t r;
    r.fired         = fired;
    r.fired_kind    = kind;
    r.next_delay    = head_gap();
    r.pending_count = CountW'(fire_time_q.size());
    r.dropped       = drop;
    r.last          = 1'b0;
    return r;
  endfunction

  // Updates the shadow store for one accepted beat and queues its results.
  task automatic predict_event_results(in_beat_t b);
    out_beat_t        res[$];
    logic [TimeW-1:0] t;
    logic [KindW-1:0] k;
    int               pos;
    case (b.opcode)
      OP_SCHEDULE: begin
        if (fire_time_q.size() >= QueueDepth) begin
          res.push_back(plain_result(1'b0, '0, 1'b1));
        end else begin
          t   = sat_sum(now_q, TimeW'(b.amount));
          pos = 0;
          while (pos < fire_time_q.size() && fire_time_q[pos] <= t) pos++;
          fire_time_q.insert(pos, t);
          fire_kind_q.insert(pos, b.event_kind);
          res.push_back(plain_result(1'b0, '0, 1'b0));
        end
      end
      OP_DESCHEDULE: begin
        for (int i = fire_kind_q.size() - 1; i >= 0; i--) begin
          if (fire_kind_q[i] == b.event_kind) begin
            fire_kind_q.delete(i);
            fire_time_q.delete(i);
          end
        end
        res.push_back(plain_result(1'b0, '0, 1'b0));
      end
      OP_ADVANCE: begin
        now_q = sat_sum(now_q, TimeW'(b.amount));
        res.push_back(plain_result(1'b0, '0, 1'b0));
      end
      OP_PROCESS: begin
        while (fire_time_q.size() > 0 && res.size() < QueueDepth &&
               fire_time_q[0] <= now_q) begin
          k = fire_kind_q.pop_front();
          void'(fire_time_q.pop_front());
          res.push_back(plain_result(1'b1, k, 1'b0));
        end
        if (res.size() == 0) res.push_back(plain_result(1'b0, '0, 1'b0));
      end
      OP_CLEAR: begin
        fire_time_q.delete();
        fire_kind_q.delete();
        now_q = '0;
        res.push_back(plain_result(1'b0, '0, 1'b0));
      end
      default: begin
        res.push_back(plain_result(1'b0, '0, 1'b0));
      end
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_beats.push_back(res[i]);
  endtask

  function automatic in_beat_t make_beat(logic [2:0] op, logic [KindW-1:0] kind,
                                         logic [AmountW-1:0] amt);
    in_beat_t b;
    b.opcode     = op;
    b.event_kind = kind;
    b.amount     = amt;
    return b;
  endfunction

  // Clock, free running from time zero.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents the oldest pending beat and moves on once it is taken.
  // Inputs change on the falling edge, so the block samples settled values.
  // Whether the beat was taken is recorded at the rising edge by the monitor,
  // since the stall seen here already belongs to the next cycle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) begin
        // The beat on the wires was taken at the last rising edge.
        void'(pending_beats.pop_front());
      end
      if (in_valid && !in_taken) begin
        // A stalled beat stays put.
      end else if (pending_beats.size() > 0 &&
                   !driver_hold && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long hold-off counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall       <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted input beat and checks each output
  // beat against the oldest expectation.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_event_results(in_data);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %p", $realtime, out_data);
          errors++;
        end else begin
          if (out_data !== expected_beats[0]) begin
            $display("%0t: mismatch expected %p actual %p", $realtime,
                     expected_beats[0], out_data);
            errors++;
          end
          void'(expected_beats.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: too long without any beat moving ends the run.
  always @(posedge clk) begin
    if (idle_cycles > StallLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random beat, weighted towards a live store: mostly schedules with short
  // delays, advances that bring events due, and processes.
  function automatic in_beat_t random_beat();
    int sel;
    logic [AmountW-1:0] amt;
    sel = $urandom_range(99);
    amt = ($urandom_range(9) == 0) ? AmountW'($urandom) : AmountW'($urandom_range(60));
    if (sel < 40) return make_beat(OP_SCHEDULE, KindW'($urandom), amt);
    if (sel < 55) return make_beat(OP_ADVANCE, KindW'($urandom), amt);
    if (sel < 80) return make_beat(OP_PROCESS, KindW'($urandom), AmountW'($urandom));
    if (sel < 90) return make_beat(OP_DESCHEDULE, KindW'($urandom), AmountW'($urandom));
    if (sel < 94) return make_beat(OP_CLEAR, KindW'($urandom), AmountW'($urandom));
    return make_beat(3'($urandom_range(7)), KindW'($urandom), AmountW'($urandom));
  endfunction

  initial begin
    errors          = 0;
    idle_cycles     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    driver_hold     = 1'b0;
    in_taken        = 1'b0;
    now_q           = '0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty process, a full store with a drop, large fire times and
    // counter advances, ties kept in insertion order, deschedule, unknown opcodes.
    pending_beats.push_back(make_beat(OP_PROCESS, 4'hF, '1));
    for (int i = 0; i < 17; i++)
      pending_beats.push_back(make_beat(OP_SCHEDULE, KindW'(i), (i % 3 == 0) ? '1 : 32'd5));
    pending_beats.push_back(make_beat(OP_DESCHEDULE, 4'h3, '0));
    pending_beats.push_back(make_beat(OP_ADVANCE, 4'h0, 32'd5));
    pending_beats.push_back(make_beat(OP_PROCESS, 4'h0, '0));
    pending_beats.push_back(make_beat(OP_ADVANCE, 4'h0, '1));
    for (int i = 0; i < 5; i++) pending_beats.push_back(make_beat(OP_ADVANCE, 4'h0, '1));
    pending_beats.push_back(make_beat(OP_SCHEDULE, 4'hA, '1));
    pending_beats.push_back(make_beat(OP_PROCESS, 4'h0, '0));
    pending_beats.push_back(make_beat(3'd5, 4'hF, '1));
    pending_beats.push_back(make_beat(3'd7, 4'h0, '0));
    pending_beats.push_back(make_beat(OP_CLEAR, 4'h0, '0));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering beats, so the
    // block holds its result beat and stalls its input.
    for (int i = 0; i < 30; i++) pending_beats.push_back(random_beat());
    hold_off_cycles = 300;
    wait_drained();

    // Random phases with different idling mixes; the sender pauses until
    // everything has drained between them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        3: begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 42; i++) pending_beats.push_back(random_beat());
      wait_drained();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> timed_event_priority_queue.f
sv/tep_pkg.sv
sv/tep_ctrl.sv
sv/tep_dpath.sv
sv/timed_event_priority_queue.sv
test/testbench.sv
